// ===== sv/bes_pkg.sv =====
// Shared constants, types and coefficient table of the Bernoulli exp sampler.
`default_nettype none

package bes_pkg;

	// Field widths
	localparam int unsigned X_W    = 64;
	localparam int unsigned CCS_W  = 63;
	localparam int unsigned RAND_W = 64;
	localparam int unsigned WORD_W = 64;

	// Range reduction: 1/ln2 as INVLN2_MANT * 2^-52, ln2 as LN2_MANT * 2^-53
	localparam logic [52:0] INVLN2_MANT = 53'd6497320848556798;
	localparam logic [52:0] LN2_MANT    = 53'd6243314768165359;
	localparam logic [55:0] LN2_Q56     = {LN2_MANT, 3'b000};

	// Exponent estimate width: x < 2^64 gives s at most 369
	localparam int unsigned S_W   = 9;
	localparam int unsigned SH_W  = 6;
	localparam logic [SH_W-1:0] SHIFT_CAP = 6'd63;

	// Horner coefficients, highest order first
	localparam int unsigned NCOEF = 13;
	localparam logic [WORD_W-1:0] POLY [NCOEF] = '{
		64'h00000004741183A3, 64'h00000036548CFC06, 64'h0000024FDCBF140A,
		64'h0000171D939DE045, 64'h0000D00CF58F6F84, 64'h000680681CF796E3,
		64'h002D82D8305B0FEA, 64'h011111110E066FD0, 64'h0555555555070F00,
		64'h155555555581FF00, 64'h400000000002B400, 64'h7FFFFFFFFFFF4800,
		64'h8000000000000000
	};

	// Pipeline shape
	localparam int unsigned FRONT_STAGES   = 5;
	localparam int unsigned FCNT_W         = $clog2(FRONT_STAGES + 1);
	localparam int unsigned QUEUE_DEPTH    = 8;
	localparam int unsigned RESULT_LATENCY = FRONT_STAGES + 1 + 2 * NCOEF + 2;

	// One reduced item as handed from the front end to the back end
	typedef struct packed {
		logic [WORD_W-1:0] z;
		logic [WORD_W-1:0] w;
		logic [SH_W-1:0]   s;
		logic [RAND_W-1:0] rnd;
	} bes_item_t;

endpackage

`default_nettype wire

// ===== sv/bes_front.sv =====
// Front end: range reduction of x into shift count s and remainder r.
`default_nettype none

module bes_front import bes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [X_W-1:0]    x_fixed,
	input  logic [CCS_W-1:0]  ccs_fixed,
	input  logic [RAND_W-1:0] rand_word,
	output logic              out_valid,
	output bes_item_t         out_item,
	output logic [FCNT_W-1:0] inflight
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [63:0]       pp_ll_s1, pp_hl_s1;
	logic [52:0]       pp_lh_s1, pp_hh_s1;
	logic [X_W-1:0]    x_s1, x_s2, x_s3;
	logic [WORD_W-1:0] w_s1, w_s2, w_s3, w_s4;
	logic [RAND_W-1:0] rnd_s1, rnd_s2, rnd_s3, rnd_s4;
	logic [S_W-1:0]    s_s2, s_s3, s_s4;
	logic [64:0]       m_s3;
	logic [WORD_W-1:0] r_s4;
	bes_item_t         item_s5;

	logic [116:0]      est_prod;
	logic              dec_corr;
	logic [WORD_W-1:0] diff;
	logic              inc_corr;
	logic [WORD_W-1:0] r_fin;
	logic [S_W-1:0]    s_fin;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// s2: x * INVLN2_MANT, keep bits 116..108 as the estimate of s
	assign est_prod = {pp_hh_s1, 64'd0}
		+ 117'({pp_lh_s1, 32'd0})
		+ 117'({pp_hl_s1, 32'd0})
		+ 117'(pp_ll_s1);

	// s4: step s down once if s*ln2 overshoots x
	assign dec_corr = (s_s3 != '0) && (m_s3 > {1'b0, x_s3});
	assign diff     = x_s3 - m_s3[63:0];

	// s5: step s up once if the remainder is still ln2 or more
	assign inc_corr = (r_s4 >= 64'(LN2_Q56));
	assign r_fin    = inc_corr ? (r_s4 - 64'(LN2_Q56)) : r_s4;
	assign s_fin    = inc_corr ? (s_s4 + S_W'(1)) : s_s4;

	// Data path registers
	always_ff @(posedge clk) begin
		// s1: four partial products of the estimate
		pp_ll_s1 <= 64'(x_fixed[31:0]) * 64'(INVLN2_MANT[31:0]);
		pp_lh_s1 <= 53'(x_fixed[31:0]) * 53'(INVLN2_MANT[52:32]);
		pp_hl_s1 <= 64'(x_fixed[63:32]) * 64'(INVLN2_MANT[31:0]);
		pp_hh_s1 <= 53'(x_fixed[63:32]) * 53'(INVLN2_MANT[52:32]);
		x_s1     <= x_fixed;
		w_s1     <= {ccs_fixed, 1'b0};
		rnd_s1   <= rand_word;

		s_s2   <= est_prod[116:108];
		x_s2   <= x_s1;
		w_s2   <= w_s1;
		rnd_s2 <= rnd_s1;

		// s3: s * ln2 in Q.56
		m_s3   <= 65'(s_s2) * 65'(LN2_Q56);
		s_s3   <= s_s2;
		x_s3   <= x_s2;
		w_s3   <= w_s2;
		rnd_s3 <= rnd_s2;

		r_s4   <= dec_corr ? (diff + 64'(LN2_Q56)) : diff;
		s_s4   <= dec_corr ? (s_s3 - S_W'(1)) : s_s3;
		w_s4   <= w_s3;
		rnd_s4 <= rnd_s3;

		// r moves to Q.64, s saturates for the final shift
		item_s5.z   <= {r_fin[55:0], 8'd0};
		item_s5.w   <= w_s4;
		item_s5.s   <= (s_fin > S_W'(SHIFT_CAP)) ? SHIFT_CAP : s_fin[SH_W-1:0];
		item_s5.rnd <= rnd_s4;
	end

	assign out_valid = valid_s5;
	assign out_item  = item_s5;
	assign inflight  = FCNT_W'(valid_s1) + FCNT_W'(valid_s2) + FCNT_W'(valid_s3)
		+ FCNT_W'(valid_s4) + FCNT_W'(valid_s5);

endmodule

`default_nettype wire

// ===== sv/bes_queue.sv =====
// Short FIFO between the front end and the back end.
`default_nettype none

module bes_queue import bes_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bes_item_t                  push_item,
	output logic                       pop_valid,
	output bes_item_t                  pop_item,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bes_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;

	// The back end never stalls, so the head item leaves every cycle
	assign pop       = (count_q != '0);
	assign pop_valid = pop;
	assign pop_item  = mem_q[rd_ptr_q];
	assign count     = count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : (wr_ptr_q + AW'(1));
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : (rd_ptr_q + AW'(1));
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== sv/bes_mul_step.sv =====
// Horner step: 64x64 high-half product in two stages, then coef - hi, or hi to scale.
`default_nettype none

module bes_mul_step import bes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [WORD_W-1:0] in_y,
	input  bes_item_t         in_item,
	input  logic [WORD_W-1:0] coef,
	input  logic              use_scale,
	output logic              out_valid,
	output logic [WORD_W-1:0] out_y,
	output bes_item_t         out_item
);

	logic              valid_s1, valid_s2;
	logic [63:0]       pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;
	bes_item_t         item_s1, item_s2;
	logic [WORD_W-1:0] y_s2;

	logic [WORD_W-1:0] oper;
	logic [33:0]       mid;
	logic [WORD_W-1:0] hi;

	// The last step scales by ccs instead of stepping the polynomial
	assign oper = use_scale ? in_item.w : in_item.z;

	// Carry out of the middle 32-bit column, then the upper half
	assign mid = 34'(pp_ll_s1[63:32]) + 34'(pp_lh_s1[31:0]) + 34'(pp_hl_s1[31:0]);
	assign hi  = pp_hh_s1 + 64'(pp_lh_s1[63:32]) + 64'(pp_hl_s1[63:32]) + 64'(mid[33:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		// s1: 32x32 partial products
		pp_ll_s1 <= 64'(oper[31:0]) * 64'(in_y[31:0]);
		pp_lh_s1 <= 64'(oper[31:0]) * 64'(in_y[63:32]);
		pp_hl_s1 <= 64'(oper[63:32]) * 64'(in_y[31:0]);
		pp_hh_s1 <= 64'(oper[63:32]) * 64'(in_y[63:32]);
		item_s1  <= in_item;
		// s2: truncated product, subtracted from coef unless use_scale is set
		y_s2    <= use_scale ? hi : (coef - hi);
		item_s2 <= item_s1;
	end

	assign out_valid = valid_s2;
	assign out_y     = y_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

// ===== sv/bes_back.sv =====
// Back end: Horner chain, ccs scaling, threshold shift and random compare.
`default_nettype none

module bes_back import bes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bes_item_t         in_item,
	output logic              done,
	output logic              accept,
	output logic [WORD_W-1:0] scaled_prob
);

	logic              step_valid [NCOEF];
	logic [WORD_W-1:0] step_y     [NCOEF];
	bes_item_t         step_item  [NCOEF];

	logic              scale_valid;
	logic [WORD_W-1:0] scale_y;
	bes_item_t         scale_item;

	logic              valid_s1;
	logic [WORD_W-1:0] t_s1;
	logic [RAND_W-1:0] rnd_s1;

	logic              done_q, accept_q;
	logic [WORD_W-1:0] prob_q;

	// Chain entry: y starts at the leading coefficient
	assign step_valid[0] = in_valid;
	assign step_y[0]     = POLY[0];
	assign step_item[0]  = in_item;

	// y = POLY[k] - hi(z * y), one two-stage unit per coefficient after the first
	for (genvar k = 1; k < NCOEF; k++) begin : g_horner
		bes_mul_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (step_valid[k-1]),
			.in_y      (step_y[k-1]),
			.in_item   (step_item[k-1]),
			.coef      (POLY[k]),
			.use_scale (1'b0),
			.out_valid (step_valid[k]),
			.out_y     (step_y[k]),
			.out_item  (step_item[k])
		);
	end

	// y = hi(w * y)
	bes_mul_step u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_valid[NCOEF-1]),
		.in_y      (step_y[NCOEF-1]),
		.in_item   (step_item[NCOEF-1]),
		.coef      ('0),
		.use_scale (1'b1),
		.out_valid (scale_valid),
		.out_y     (scale_y),
		.out_item  (scale_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= scale_valid;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		// s1: threshold = (2y - 1 mod 2^64) >> s
		t_s1   <= ({scale_y[62:0], 1'b0} - 64'd1) >> scale_item.s;
		rnd_s1 <= scale_item.rnd;
		// s2: compare and present
		accept_q <= (rnd_s1 < t_s1);
		prob_q   <= t_s1;
	end

	assign done        = done_q;
	assign accept      = accept_q;
	assign scaled_prob = prob_q;

endmodule

`default_nettype wire

// ===== sv/bernoulli_exp_sampler.sv =====
// Top level of the Bernoulli exp sampler: front end, queue and back end.
`default_nettype none

// Draws a Bernoulli bit with probability ccs * exp(-x).
// Input: an item (x_fixed Q8.56, ccs_fixed Q0.63, rand_word) is taken at a
// rising edge where start is high and busy is low.
// Output: done is high for exactly one cycle per item, with accept and
// scaled_prob valid in that same cycle. Results leave in input order.
// Path from the accepting edge to the edge that takes the result:
// 5 range reduction stages, the queue, 13 two-stage 64x64 high-half
// multiply units (12 Horner steps plus the ccs scaling), and 2 stages
// for the shift and compare.
// Throughput: one item per cycle while busy is low. busy rises only when items in the
// front end plus items in the queue reach the queue depth; since the back
// end drains one item every cycle this never happens at the default depth.
// The receiver cannot stall; every result is shown once and is gone.
// Reset (arst_n low) empties all stages and the queue; items in flight are
// dropped and no done pulse follows for them.

module bernoulli_exp_sampler import bes_pkg::*; #(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [X_W-1:0]    x_fixed,
	input  logic [CCS_W-1:0]  ccs_fixed,
	input  logic [RAND_W-1:0] rand_word,
	output logic              done,
	output logic              accept,
	output logic [WORD_W-1:0] scaled_prob
);

	localparam int unsigned QCW = $clog2(QDEPTH + 1);
	localparam int unsigned OCW = $clog2(QDEPTH + FRONT_STAGES + 1);

	logic              take;
	logic              fe_valid;
	bes_item_t         fe_item;
	logic [FCNT_W-1:0] fe_inflight;
	logic              q_valid;
	bes_item_t         q_item;
	logic [QCW-1:0]    q_count;

	// Hold off new items once every queue slot is spoken for
	assign busy = (OCW'(fe_inflight) + OCW'(q_count)) >= OCW'(QDEPTH);
	assign take = start && !busy;

	bes_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (take),
		.x_fixed   (x_fixed),
		.ccs_fixed (ccs_fixed),
		.rand_word (rand_word),
		.out_valid (fe_valid),
		.out_item  (fe_item),
		.inflight  (fe_inflight)
	);

	bes_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_valid),
		.push_item (fe_item),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.count     (q_count)
	);

	bes_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_valid),
		.in_item     (q_item),
		.done        (done),
		.accept      (accept),
		.scaled_prob (scaled_prob)
	);

endmodule

`default_nettype wire

// ===== sv/bes_checker.sv =====
// Port-level checker for the Bernoulli exp sampler and its bind.
`default_nettype none

module bes_checker import bes_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              accept,
	input logic [WORD_W-1:0] scaled_prob
);

	// Every accepted item comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##RESULT_LATENCY done)
		else $error("result missing after accepted item");

	// No result without an item accepted the latency before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, RESULT_LATENCY))
		else $error("result without matching item");

	// Acceptance needs a nonzero threshold
	a_accept_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accept) |-> (scaled_prob != '0))
		else $error("accept with zero threshold");

	// Empty after reset, so the block takes items at once
	a_reset_ready: assert property (@(posedge clk)
		$rose(arst_n) |-> !busy)
		else $error("busy right after reset");

endmodule

bind bernoulli_exp_sampler bes_checker u_bes_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.accept      (accept),
	.scaled_prob (scaled_prob)
);

`default_nettype wire
